[hdl/ffba_pkg.sv]
// shared types and codes for the first-fit block allocator
package ffba_pkg;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_REALLOC = 2'd2,
      CMD_RSVD    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NULL    = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_SCAN,
      S_APPEND,
      S_FREE_OLD,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_BIDX,
      RD_ZERO,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_MARK_USED,
      WR_FREE_ENTRY,
      WR_APPEND,
      WR_FREE_OLD
   } wr_sel_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_NULL,
      RES_FULL,
      RES_INVALID,
      RES_KEEP,
      RES_FREED,
      RES_SCAN,
      RES_APPEND
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      res_sel_type res_sel;
      logic        save_old;
      logic        count_inc;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    has_block;
      logic    bidx_valid;
      logic    size_zero;
      logic    count_zero;
      logic    table_full;
      logic    entry_free;
      logic    entry_fits;
      logic    scan_last;
      logic    out_ready;
   } dp_stat_type;

endpackage

[hdl/first_fit_block_allocator.sv]
// first-fit block allocator top level
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_cmd req_size req_has_block req_block_index
//   rsp      out        rsp_valid/rsp_stall  rsp_status rsp_result_index rsp_reused
//
// one item at a time; an item that fails decode goes straight to the result, one that
// ends at the block check (free, keep, invalid) reads its entry first, a free block
// that fits is found by a first-fit scan of the entries, and otherwise the item
// appends or finds the table full; a reallocate that grows also frees its old block
// unless the table is full. the next item is taken in the cycle after the result
// loads. reset clears the block count and the output valid only, so the table needs
// no clearing pass. a held result does not block the next item until that item's own
// result is ready
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_size,
   input  logic        req_has_block,
   input  logic [5:0]  req_block_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_result_index,
   output logic        rsp_reused
);
   import ffba_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   ffba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_size         (req_size),
      .req_has_block    (req_has_block),
      .req_block_index  (req_block_index),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_reused       (rsp_reused),
      .dp_cmd           (dp_cmd),
      .dp_stat          (dp_stat)
   );

endmodule

[hdl/ffba_ram.sv]
// generic simple dual-port ram with registered read
module ffba_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ffba_datapath.sv]
// block table, item registers, scan pointer, result and output registers
module ffba_datapath #(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_cmd,
   input  logic [31:0]          req_size,
   input  logic                 req_has_block,
   input  logic [5:0]           req_block_index,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [5:0]           rsp_result_index,
   output logic                 rsp_reused,
   input  ffba_pkg::dp_cmd_type dp_cmd,
   output ffba_pkg::dp_stat_type dp_stat
);
   import ffba_pkg::*;

   localparam int IW   = $clog2(MAX_BLOCKS);
   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;
   localparam int EW   = SIZE_BITS + 1;

   cmd_type              cmd_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic                 has_ff;
   logic [5:0]           bidx_ff;
   logic [SIZE_BITS-1:0] old_size_ff;
   logic [CW-1:0]        count_ff;
   logic [IW-1:0]        scan_addr_ff, scan_addr_in;

   status_type           res_status_ff, res_status_in;
   logic [IW-1:0]        res_idx_ff, res_idx_in;
   logic                 res_reused_ff, res_reused_in;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [5:0]           rsp_idx_ff;
   logic                 rsp_reused_ff;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr, rd_addr;
   logic [EW-1:0]        wr_data, rd_data;
   logic [SIZE_BITS-1:0] rd_size;
   logic                 rd_free;

   assign rd_size = rd_data[SIZE_BITS-1:0];
   assign rd_free = rd_data[SIZE_BITS];

   ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read address and scan pointer
   always_comb begin
      rd_addr      = IW'(bidx_ff);
      scan_addr_in = scan_addr_ff;
      case (dp_cmd.rd_sel)
         RD_ZERO: begin
            rd_addr      = '0;
            scan_addr_in = '0;
         end
         RD_NEXT: begin
            rd_addr      = scan_addr_ff + IW'(1);
            scan_addr_in = scan_addr_ff + IW'(1);
         end
         default: ;
      endcase
   end

   // table write: entry layout is {free mark, size}
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = IW'(bidx_ff);
      wr_data = {1'b1, old_size_ff};
      case (dp_cmd.wr_sel)
         WR_MARK_USED: begin
            wr_addr = scan_addr_ff;
            wr_data = {1'b0, rd_size};
         end
         WR_FREE_ENTRY: begin
            wr_data = {1'b1, rd_size};
         end
         WR_APPEND: begin
            wr_addr = IW'(count_ff);
            wr_data = {1'b0, size_ff};
         end
         WR_FREE_OLD: ;
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_reused_in = res_reused_ff;
      case (dp_cmd.res_sel)
         RES_NULL: begin
            res_status_in = ST_NULL;
            res_idx_in    = '0;
            res_reused_in = 1'b0;
         end
         RES_FULL: begin
            res_status_in = ST_FULL;
            res_idx_in    = '0;
            res_reused_in = 1'b0;
         end
         RES_INVALID: begin
            res_status_in = ST_INVALID;
            res_idx_in    = '0;
            res_reused_in = 1'b0;
         end
         RES_KEEP: begin
            res_status_in = ST_OK;
            res_idx_in    = IW'(bidx_ff);
            res_reused_in = 1'b1;
         end
         RES_FREED: begin
            res_status_in = ST_OK;
            res_idx_in    = IW'(bidx_ff);
            res_reused_in = 1'b0;
         end
         RES_SCAN: begin
            res_status_in = ST_OK;
            res_idx_in    = scan_addr_ff;
            res_reused_in = 1'b1;
         end
         RES_APPEND: begin
            res_status_in = ST_OK;
            res_idx_in    = IW'(count_ff);
            res_reused_in = 1'b0;
         end
         default: ;
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff  <= cmd_type'(req_cmd);
         size_ff <= SIZE_BITS'(req_size);
         has_ff  <= req_has_block;
         bidx_ff <= req_block_index;
      end
      if (dp_cmd.save_old) begin
         old_size_ff <= rd_size;
      end
      scan_addr_ff  <= scan_addr_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_reused_ff <= res_reused_in;
      if (dp_cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_idx_ff    <= 6'(res_idx_ff);
         rsp_reused_ff <= res_reused_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.count_inc) begin
            count_ff <= count_ff + CW'(1);
         end
         if (dp_cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      dp_stat.cmd        = cmd_ff;
      dp_stat.has_block  = has_ff;
      dp_stat.bidx_valid = has_ff && (CMPW'(bidx_ff) < CMPW'(count_ff));
      dp_stat.size_zero  = (size_ff == '0);
      dp_stat.count_zero = (count_ff == '0);
      dp_stat.table_full = (count_ff == CW'(MAX_BLOCKS));
      dp_stat.entry_free = rd_free;
      dp_stat.entry_fits = (rd_size >= size_ff);
      dp_stat.scan_last  = ((CW'(scan_addr_ff) + CW'(1)) == count_ff);
      dp_stat.out_ready  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_reused       = rsp_reused_ff;

endmodule

[hdl/ffba_ctrl.sv]
// allocator sequencer: decode, first-fit scan, append and result hand-off
module ffba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output ffba_pkg::dp_cmd_type  dp_cmd,
   input  ffba_pkg::dp_stat_type dp_stat
);
   import ffba_pkg::*;

   state_type state_ff, state_in;
   logic      grow_ff, grow_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         grow_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         grow_ff  <= grow_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (dp_stat.cmd) inside
               CMD_FREE: begin
                  if (dp_stat.has_block && dp_stat.bidx_valid) state_in = S_CHECK;
                  else                                       state_in = S_FINISH;
               end
               CMD_ALLOC, CMD_REALLOC: begin
                  if (dp_stat.cmd == CMD_REALLOC && dp_stat.has_block) begin
                     state_in = dp_stat.bidx_valid ? S_CHECK : S_FINISH;
                  end else if (dp_stat.size_zero) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = dp_stat.count_zero ? S_APPEND : S_SCAN;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_CHECK: begin
            if (dp_stat.entry_free || dp_stat.cmd == CMD_FREE || dp_stat.entry_fits) begin
               state_in = S_FINISH;
            end else begin
               state_in = dp_stat.count_zero ? S_APPEND : S_SCAN;
            end
         end
         S_SCAN: begin
            if (dp_stat.entry_free && dp_stat.entry_fits) begin
               state_in = grow_ff ? S_FREE_OLD : S_FINISH;
            end else if (dp_stat.scan_last) begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            if (dp_stat.table_full) state_in = S_FINISH;
            else                    state_in = grow_ff ? S_FREE_OLD : S_FINISH;
         end
         S_FREE_OLD: state_in = S_FINISH;
         S_FINISH: begin
            if (dp_stat.out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      req_stall        = (state_ff != S_IDLE);
      grow_in          = grow_ff;
      dp_cmd.capture   = 1'b0;
      dp_cmd.rd_sel    = RD_BIDX;
      dp_cmd.wr_sel    = WR_NONE;
      dp_cmd.res_sel   = RES_HOLD;
      dp_cmd.save_old  = 1'b0;
      dp_cmd.count_inc = 1'b0;
      dp_cmd.out_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            dp_cmd.capture = req_valid;
            grow_in        = 1'b0;
         end
         S_DECODE: begin
            unique case (dp_stat.cmd) inside
               CMD_FREE: begin
                  if (!dp_stat.has_block)      dp_cmd.res_sel = RES_NULL;
                  else if (!dp_stat.bidx_valid) dp_cmd.res_sel = RES_INVALID;
               end
               CMD_ALLOC, CMD_REALLOC: begin
                  if (dp_stat.cmd == CMD_REALLOC && dp_stat.has_block) begin
                     if (!dp_stat.bidx_valid) dp_cmd.res_sel = RES_INVALID;
                  end else if (dp_stat.size_zero) begin
                     dp_cmd.res_sel = RES_NULL;
                  end else begin
                     dp_cmd.rd_sel = RD_ZERO;
                  end
               end
               default: dp_cmd.res_sel = RES_NULL;
            endcase
         end
         S_CHECK: begin
            if (dp_stat.entry_free) begin
               dp_cmd.res_sel = RES_INVALID;
            end else if (dp_stat.cmd == CMD_FREE) begin
               dp_cmd.wr_sel  = WR_FREE_ENTRY;
               dp_cmd.res_sel = RES_FREED;
            end else if (dp_stat.entry_fits) begin
               dp_cmd.res_sel = RES_KEEP;
            end else begin
               // growth: keep the old size so the old block can be freed later
               dp_cmd.save_old = 1'b1;
               dp_cmd.rd_sel   = RD_ZERO;
               grow_in         = 1'b1;
            end
         end
         S_SCAN: begin
            if (dp_stat.entry_free && dp_stat.entry_fits) begin
               dp_cmd.wr_sel  = WR_MARK_USED;
               dp_cmd.res_sel = RES_SCAN;
            end else if (!dp_stat.scan_last) begin
               dp_cmd.rd_sel = RD_NEXT;
            end
         end
         S_APPEND: begin
            if (dp_stat.table_full) begin
               dp_cmd.res_sel = RES_FULL;
            end else begin
               dp_cmd.wr_sel    = WR_APPEND;
               dp_cmd.res_sel   = RES_APPEND;
               dp_cmd.count_inc = 1'b1;
            end
         end
         S_FREE_OLD: dp_cmd.wr_sel = WR_FREE_OLD;
         S_FINISH:   dp_cmd.out_load = dp_stat.out_ready;
         default: ;
      endcase
   end

endmodule
